/* sv/assert_macros.svh */
// Assertion helpers used by split_frequency_table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, cond, cons, msg) \
   `ASSERT_CLK(label, (cond) |-> (cons), msg)

`endif

/* sv/sft_pkg.sv */
package sft_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int OCC_BITS      = $clog2(TABLE_ENTRIES + 1);
   localparam int COUNT_BITS    = 16;
   localparam int KEY_BITS      = 64;
   localparam int SIZE_BITS     = 8;
   localparam int TIP_BITS      = 8;
   localparam int OUT_BITS      = 16;
   localparam int HASH_IN_BITS  = 2 * KEY_BITS + SIZE_BITS;

   localparam logic [TIP_BITS-1:0] TIP_COUNT_RESET = 8'd128;

   typedef enum logic {
      KIND_RECORD = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key_low;
      logic [KEY_BITS-1:0]   key_high;
      logic [SIZE_BITS-1:0]  size;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // Folds the key and split size onto a slot index with an XOR tree.
   function automatic logic [IDX_BITS-1:0] home_slot(input logic [KEY_BITS-1:0]  lo,
                                                     input logic [KEY_BITS-1:0]  hi,
                                                     input logic [SIZE_BITS-1:0] size);
      logic [HASH_IN_BITS-1:0] v;
      logic [IDX_BITS-1:0]     h;
      v = {size, hi, lo};
      h = '0;
      for (int i = 0; i < HASH_IN_BITS; i++) begin
         h[i % IDX_BITS] = h[i % IDX_BITS] ^ v[i];
      end
      return h;
   endfunction

   // Caps a stored count to the width of the result field.
   function automatic logic [OUT_BITS-1:0] cap_count(input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS+OUT_BITS-1:0] w;
      logic [COUNT_BITS+OUT_BITS-1:0] lim;
      w   = {{OUT_BITS{1'b0}}, c};
      lim = {{COUNT_BITS{1'b0}}, {OUT_BITS{1'b1}}};
      return (w > lim) ? {OUT_BITS{1'b1}} : w[OUT_BITS-1:0];
   endfunction

endpackage

/* sv/sft_if.sv */
interface sft_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [sft_pkg::KEY_BITS-1:0]    key_word_low;
   logic [sft_pkg::KEY_BITS-1:0]    key_word_high;
   logic [sft_pkg::SIZE_BITS-1:0]   split_size;

   modport source (output valid, kind, key_word_low, key_word_high, split_size,
                   input  ready);
   modport sink   (input  valid, kind, key_word_low, key_word_high, split_size,
                   output ready);
endinterface

interface sft_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sft_pkg::OUT_BITS-1:0]    match_count;
   logic                            was_present;
   logic                            is_trivial;
   logic                            dropped;

   modport source (output valid, match_count, was_present, is_trivial, dropped,
                   input  ready);
   modport sink   (input  valid, match_count, was_present, is_trivial, dropped,
                   output ready);
endinterface

/* sv/split_frequency_table.sv */
// Split frequency table: counts how often each bipartition key is seen.
// Items arrive on the req channel (valid/ready). A record item adds one
// occurrence of its key, making a new entry if needed; a query item only
// reads the count. Every item gives exactly one item on the rsp channel with
// the count after the operation, a found flag, a trivial-split flag and a
// dropped flag for a new key refused by a full table. The csr port writes
// tip_count, which is only used to find trivial splits.
// The table lives in one single-port-read, single-port-write memory with a
// registered read. An item is accepted in the idle state, which also reads
// its home slot; the check state then tests one slot of the linear probe
// sequence at a time, and the done state loads the output register. The
// probe visits 1 slot for a hit or a free slot at the home slot, up to 1024
// for a full table. The next item is accepted once the current one has
// reached the output register, so the block keeps working while a result
// waits to be taken. If the receiver stalls, a finished item waits in the
// done state until the output register is free; nothing is lost or repeated.
// After reset the block runs a clearing pass that marks every slot empty;
// req.ready stays low during it, while csr writes are taken.
module split_frequency_table (
   input  logic                           clock,
   input  logic                           reset,
   sft_req_if.sink                        req,
   sft_rsp_if.source                      rsp,
   input  logic                           csr_wr_en,
   input  logic [sft_pkg::TIP_BITS-1:0]   csr_wr_data
);

`include "assert_macros.svh"

   localparam logic [sft_pkg::IDX_BITS-1:0] LAST_IDX =
      sft_pkg::IDX_BITS'(sft_pkg::TABLE_ENTRIES - 1);
   localparam logic [sft_pkg::OCC_BITS-1:0] FULL_OCC =
      sft_pkg::OCC_BITS'(sft_pkg::TABLE_ENTRIES);

   // Table storage. Each word carries its own valid mark.
   sft_pkg::entry_type mem [sft_pkg::TABLE_ENTRIES];
   sft_pkg::entry_type rd_data_ff;
   logic [sft_pkg::IDX_BITS-1:0] rd_addr;
   logic                         wr_en;
   logic [sft_pkg::IDX_BITS-1:0] wr_addr;
   sft_pkg::entry_type           wr_data;

   // Control state.
   sft_pkg::state_type state_ff, state_in;
   logic [sft_pkg::IDX_BITS-1:0] clr_ff, clr_in;
   logic [sft_pkg::IDX_BITS-1:0] probe_ff, probe_in;
   logic [sft_pkg::IDX_BITS-1:0] probes_ff, probes_in;
   logic [sft_pkg::OCC_BITS-1:0] occ_ff, occ_in;
   logic [sft_pkg::TIP_BITS-1:0] tip_ff, tip_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Item being worked on.
   logic                          kind_ff, kind_in;
   logic [sft_pkg::KEY_BITS-1:0]  lo_ff, lo_in;
   logic [sft_pkg::KEY_BITS-1:0]  hi_ff, hi_in;
   logic [sft_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic                          triv_ff, triv_in;

   // Result waiting for the output register.
   logic [sft_pkg::OUT_BITS-1:0]  res_count_ff, res_count_in;
   logic                          res_present_ff, res_present_in;
   logic                          res_dropped_ff, res_dropped_in;

   // Output register.
   logic [sft_pkg::OUT_BITS-1:0]  out_count_ff, out_count_in;
   logic                          out_present_ff, out_present_in;
   logic                          out_trivial_ff, out_trivial_in;
   logic                          out_dropped_ff, out_dropped_in;

   logic                          hit;
   logic                          is_record;
   logic [sft_pkg::COUNT_BITS-1:0] inc_count;
   logic [sft_pkg::SIZE_BITS:0]   size_plus_two;

   assign req.ready       = (state_ff == sft_pkg::ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.match_count = out_count_ff;
   assign rsp.was_present = out_present_ff;
   assign rsp.is_trivial  = out_trivial_ff;
   assign rsp.dropped     = out_dropped_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign hit = rd_data_ff.valid && (rd_data_ff.key_low == lo_ff) &&
                (rd_data_ff.key_high == hi_ff) && (rd_data_ff.size == size_ff);
   assign is_record = (kind_ff == sft_pkg::KIND_RECORD);
   // The count saturates at its all-ones value.
   assign inc_count = (&rd_data_ff.count) ? rd_data_ff.count :
                      rd_data_ff.count + sft_pkg::COUNT_BITS'(1);
   assign size_plus_two = {1'b0, req.split_size} + (sft_pkg::SIZE_BITS + 1)'(2);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      probe_in       = probe_ff;
      probes_in      = probes_ff;
      occ_in         = occ_ff;
      tip_in         = csr_wr_en ? csr_wr_data : tip_ff;
      kind_in        = kind_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      size_in        = size_ff;
      triv_in        = triv_ff;
      res_count_in   = res_count_ff;
      res_present_in = res_present_ff;
      res_dropped_in = res_dropped_ff;
      out_count_in   = out_count_ff;
      out_present_in = out_present_ff;
      out_trivial_in = out_trivial_ff;
      out_dropped_in = out_dropped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rd_addr        = probe_ff;
      wr_en          = 1'b0;
      wr_addr        = probe_ff;
      wr_data        = rd_data_ff;

      unique case (state_ff)
         sft_pkg::ST_CLEAR: begin
            // Mark one slot empty per cycle.
            wr_en         = 1'b1;
            wr_addr       = clr_ff;
            wr_data       = '0;
            clr_in        = clr_ff + sft_pkg::IDX_BITS'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = sft_pkg::ST_IDLE;
            end
         end
         sft_pkg::ST_IDLE: begin
            rd_addr = sft_pkg::home_slot(req.key_word_low, req.key_word_high,
                                         req.split_size);
            if (req.valid) begin
               kind_in   = req.kind;
               lo_in     = req.key_word_low;
               hi_in     = req.key_word_high;
               size_in   = req.split_size;
               triv_in   = (req.split_size < sft_pkg::SIZE_BITS'(2)) ||
                           (size_plus_two > {1'b0, tip_ff});
               probe_in  = rd_addr;
               probes_in = '0;
               state_in  = sft_pkg::ST_CHECK;
            end
         end
         sft_pkg::ST_CHECK: begin
            res_present_in = 1'b0;
            res_dropped_in = 1'b0;
            res_count_in   = '0;
            if (hit) begin
               res_present_in = 1'b1;
               if (is_record) begin
                  wr_en         = 1'b1;
                  wr_data.count = inc_count;
                  res_count_in  = sft_pkg::cap_count(inc_count);
               end else begin
                  res_count_in  = sft_pkg::cap_count(rd_data_ff.count);
               end
               state_in = sft_pkg::ST_DONE;
            end else if (!rd_data_ff.valid) begin
               // A free slot ends the probe; a record claims it.
               if (is_record) begin
                  if (occ_ff < FULL_OCC) begin
                     wr_en            = 1'b1;
                     wr_data.valid    = 1'b1;
                     wr_data.key_low  = lo_ff;
                     wr_data.key_high = hi_ff;
                     wr_data.size     = size_ff;
                     wr_data.count    = sft_pkg::COUNT_BITS'(1);
                     occ_in           = occ_ff + sft_pkg::OCC_BITS'(1);
                     res_count_in     = sft_pkg::OUT_BITS'(1);
                  end else begin
                     res_dropped_in   = 1'b1;
                  end
               end
               state_in = sft_pkg::ST_DONE;
            end else if (probes_ff == LAST_IDX) begin
               // Every slot holds another key: the table is full.
               res_dropped_in = is_record;
               state_in       = sft_pkg::ST_DONE;
            end else begin
               probe_in  = (probe_ff == LAST_IDX) ? '0 : probe_ff + sft_pkg::IDX_BITS'(1);
               probes_in = probes_ff + sft_pkg::IDX_BITS'(1);
               rd_addr   = probe_in;
            end
         end
         sft_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_count_in   = res_count_ff;
               out_present_in = res_present_ff;
               out_trivial_in = triv_ff;
               out_dropped_in = res_dropped_ff;
               rsp_valid_in   = 1'b1;
               state_in       = sft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sft_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sft_pkg::ST_CLEAR;
         clr_ff       <= '0;
         probe_ff     <= '0;
         probes_ff    <= '0;
         occ_ff       <= '0;
         tip_ff       <= sft_pkg::TIP_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         probe_ff     <= probe_in;
         probes_ff    <= probes_in;
         occ_ff       <= occ_in;
         tip_ff       <= tip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      size_ff        <= size_in;
      triv_ff        <= triv_in;
      res_count_ff   <= res_count_in;
      res_present_ff <= res_present_in;
      res_dropped_ff <= res_dropped_in;
      out_count_ff   <= out_count_in;
      out_present_ff <= out_present_in;
      out_trivial_ff <= out_trivial_in;
      out_dropped_ff <= out_dropped_in;
   end

   // A dropped key can only come from a table with every slot in use.
   `ASSERT_IMPLY(a_drop_when_full, rsp.valid && rsp.dropped, occ_ff == FULL_OCC,
                 "dropped item while the table has free slots")
   // The fill count only ever grows by one entry at a time.
   `ASSERT_CLK(a_occ_step, (occ_ff == $past(occ_ff)) ||
               (occ_ff == $past(occ_ff) + sft_pkg::OCC_BITS'(1)),
               "fill count changed by more than one entry")
   // A key that was found always has a nonzero count.
   `ASSERT_IMPLY(a_present_count, rsp.valid && rsp.was_present, rsp.match_count != '0,
                 "found key reported with a zero count")

endmodule
